@@ rtl/oag_pkg.sv @@
// shared types and constants for the operand address generator
package oag_pkg;

	localparam logic       OP_START = 1'b0;
	localparam logic       OP_DATA  = 1'b1;

	localparam logic [3:0] MODE_IMP  = 4'd0;
	localparam logic [3:0] MODE_ACC  = 4'd1;
	localparam logic [3:0] MODE_ABS  = 4'd2;
	localparam logic [3:0] MODE_ABSX = 4'd3;
	localparam logic [3:0] MODE_ABSY = 4'd4;
	localparam logic [3:0] MODE_IMM  = 4'd5;
	localparam logic [3:0] MODE_ZP   = 4'd6;
	localparam logic [3:0] MODE_ZPX  = 4'd7;
	localparam logic [3:0] MODE_ZPY  = 4'd8;
	localparam logic [3:0] MODE_IND  = 4'd9;
	localparam logic [3:0] MODE_INDX = 4'd10;
	localparam logic [3:0] MODE_INDY = 4'd11;
	localparam logic [3:0] MODE_REL  = 4'd12;

	localparam logic [1:0] KIND_READ = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_SKIP = 2'd2;

	localparam logic [1:0] STEP_LOW     = 2'd0;
	localparam logic [1:0] STEP_HIGH    = 2'd1;
	localparam logic [1:0] STEP_PTR_LOW = 2'd2;
	localparam logic [1:0] STEP_PTR_HI  = 2'd3;

	typedef struct packed {
		logic        op;
		logic [3:0]  mode;
		logic [15:0] pc;
		logic [7:0]  x_index;
		logic [7:0]  y_index;
		logic [7:0]  read_data;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] address;
		logic [15:0] next_pc;
	} result_t;

	typedef struct packed {
		logic        busy;
		logic [3:0]  held_mode;
		logic [1:0]  step_count;
		logic [15:0] program_counter;
		logic [7:0]  held_x;
		logic [7:0]  held_y;
		logic [7:0]  low_byte;
		logic [15:0] pointer_address;
	} agen_state_t;

endpackage

@@ rtl/oag_step.sv @@
// next-state and result logic for one transaction
module oag_step import oag_pkg::*; (
	input  item_t       item,
	input  agen_state_t cur,
	output agen_state_t nxt,
	output result_t     result
);

	logic [15:0] word;
	logic [15:0] rel_off;

	assign word    = {item.read_data, cur.low_byte};
	assign rel_off = {{8{item.read_data[7]}}, item.read_data};

	always_comb begin
		nxt    = cur;
		result = '{kind: KIND_SKIP, address: 16'd0, next_pc: 16'd0};
		if (item.op == OP_START) begin
			nxt.held_mode       = item.mode;
			nxt.program_counter = item.pc;
			nxt.held_x          = item.x_index;
			nxt.held_y          = item.y_index;
			nxt.low_byte        = 8'd0;
			nxt.pointer_address = 16'd0;
			nxt.step_count      = STEP_LOW;
			nxt.busy            = 1'b0;
			if (item.mode == MODE_IMM) begin
				result = '{kind: KIND_DONE, address: item.pc, next_pc: item.pc + 16'd1};
			end else if (item.mode < MODE_ABS || item.mode > MODE_REL) begin
				result = '{kind: KIND_DONE, address: item.pc, next_pc: item.pc};
			end else begin
				nxt.busy = 1'b1;
				result   = '{kind: KIND_READ, address: item.pc, next_pc: 16'd0};
			end
		end else if (cur.busy) begin
			// finishing clears busy and step; read requests override below
			case (cur.held_mode)
				MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_IND: begin
					if (cur.step_count == STEP_LOW) begin
						nxt.low_byte   = item.read_data;
						nxt.step_count = STEP_HIGH;
						result = '{kind: KIND_READ, address: cur.program_counter + 16'd1,
							next_pc: 16'd0};
					end else if (cur.step_count == STEP_HIGH) begin
						if (cur.held_mode == MODE_IND) begin
							nxt.pointer_address = word;
							nxt.step_count      = STEP_PTR_LOW;
							result = '{kind: KIND_READ, address: word, next_pc: 16'd0};
						end else begin
							nxt.busy       = 1'b0;
							nxt.step_count = STEP_LOW;
							result.kind    = KIND_DONE;
							result.next_pc = cur.program_counter + 16'd2;
							if (cur.held_mode == MODE_ABSX)
								result.address = word + {8'd0, cur.held_x};
							else if (cur.held_mode == MODE_ABSY)
								result.address = word + {8'd0, cur.held_y};
							else
								result.address = word;
						end
					end
				end
				MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_REL: begin
					nxt.busy       = 1'b0;
					nxt.step_count = STEP_LOW;
					result.kind    = KIND_DONE;
					result.next_pc = cur.program_counter + 16'd1;
					if (cur.held_mode == MODE_ZPX)
						result.address = {8'd0, item.read_data + cur.held_x};
					else if (cur.held_mode == MODE_ZPY)
						result.address = {8'd0, item.read_data + cur.held_y};
					else if (cur.held_mode == MODE_REL)
						result.address = cur.program_counter + 16'd1 + rel_off;
					else
						result.address = {8'd0, item.read_data};
				end
				MODE_INDX, MODE_INDY: begin
					if (cur.step_count == STEP_LOW) begin
						// zero-page pointer wraps within page zero
						nxt.pointer_address = (cur.held_mode == MODE_INDX) ?
							{8'd0, item.read_data + cur.held_x} : {8'd0, item.read_data};
						nxt.step_count = STEP_PTR_LOW;
						result = '{kind: KIND_READ, address: nxt.pointer_address,
							next_pc: 16'd0};
					end
				end
				default: begin
					nxt.busy       = 1'b0;
					nxt.step_count = STEP_LOW;
				end
			endcase

			// pointer dereference shared by the indirect modes
			if ((cur.held_mode == MODE_IND && cur.step_count[1]) ||
			    ((cur.held_mode == MODE_INDX || cur.held_mode == MODE_INDY) &&
			     cur.step_count != STEP_LOW)) begin
				if (cur.step_count == STEP_PTR_LOW) begin
					nxt.low_byte   = item.read_data;
					nxt.step_count = STEP_PTR_HI;
					// high byte stays within the pointer's page
					result = '{kind: KIND_READ,
						address: {cur.pointer_address[15:8], cur.pointer_address[7:0] + 8'd1},
						next_pc: 16'd0};
				end else begin
					nxt.busy       = 1'b0;
					nxt.step_count = STEP_LOW;
					result.kind    = KIND_DONE;
					if (cur.held_mode == MODE_IND) begin
						result.address = word;
						result.next_pc = cur.program_counter + 16'd2;
					end else if (cur.held_mode == MODE_INDY) begin
						result.address = word + {8'd0, cur.held_y};
						result.next_pc = cur.program_counter + 16'd1;
					end else begin
						result.address = word;
						result.next_pc = cur.program_counter + 16'd1;
					end
				end
			end
		end
	end

endmodule

@@ rtl/oag_out_buf.sv @@
// result register with a skid stage
module oag_out_buf import oag_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    valid,
	input  logic    stall,
	output result_t data
);

	logic    skid_valid_q;
	result_t skid_q;
	logic    pop;

	assign pop   = valid & ~stall;
	assign full  = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid        <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				data         <= skid_q;
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!valid || pop) begin
				data  <= push_data;
				valid <= 1'b1;
			end else begin
				skid_q       <= push_data;
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			valid <= 1'b0;
		end
	end

endmodule

@@ rtl/operand_address_generator_top.sv @@
// operand address generator top level: input register, step logic, result buffer
//
//  channel  | valid         | stall         | payload
//  ---------+---------------+---------------+-------------------------------
//  input    | item_valid    | item_stall    | item   (op, mode, pc, x, y, data)
//  output   | result_valid  | result_stall  | result (kind, address, next_pc)
//
// one transaction per clock sustained while item_stall is low.
// the input register feeds one pass of combinational logic into the result
// register, which updates the fetch state in the same cycle.
// arst_n clears the valid bits and the fetch state (idle, all zero).
// a two-entry result buffer absorbs a stall; item_stall rises only when full.
module operand_address_generator_top import oag_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic        valid_s1;
	item_t       item_s1;
	agen_state_t state_q;
	agen_state_t state_nxt;
	result_t     step_result;
	logic        buf_full;
	logic        advance;

	assign advance    = valid_s1 & ~buf_full;
	assign item_stall = valid_s1 & buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	oag_step u_step (
		.item   (item_s1),
		.cur    (state_q),
		.nxt    (state_nxt),
		.result (step_result)
	);

	oag_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_data (step_result),
		.full      (buf_full),
		.valid     (result_valid),
		.stall     (result_stall),
		.data      (result)
	);

endmodule

@@ tb/sv/agen_check_pkg.sv @@
`timescale 1ns / 1ps
// result prediction and checking for the operand address generator bench
package agen_check_pkg;
	import oag_pkg::*;

	class agen_scoreboard;
		agen_state_t st;
		result_t     expected_results[$];
		int          errors;

		function new();
			st = '0;
			errors = 0;
		endfunction

		function result_t finish_fetch(logic [15:0] addr, logic [15:0] consumed);
			result_t r;
			st.busy = 1'b0;
			st.step_count = STEP_LOW;
			r.kind = KIND_DONE;
			r.address = addr;
			r.next_pc = st.program_counter + consumed;
			return r;
		endfunction

		function result_t read_request(logic [15:0] addr, logic [1:0] next_step);
			result_t r;
			st.step_count = next_step;
			r.kind = KIND_READ;
			r.address = addr;
			r.next_pc = 16'h0000;
			return r;
		endfunction

		function result_t skipped();
			result_t r;
			r = '0;
			r.kind = KIND_SKIP;
			return r;
		endfunction

		// advances the fetch state by one transaction and returns its result
		function result_t fetch_step(item_t it);
			logic [15:0] word;
			logic [7:0]  zp_x_sum;
			logic [7:0]  zp_y_sum;
			logic [15:0] offset;
			if (it.op == OP_START) begin
				st.held_mode = it.mode;
				st.program_counter = it.pc;
				st.held_x = it.x_index;
				st.held_y = it.y_index;
				st.low_byte = 8'h00;
				st.pointer_address = 16'h0000;
				st.step_count = STEP_LOW;
				st.busy = 1'b0;
				if (it.mode == MODE_IMM)
					return finish_fetch(it.pc, 16'd1);
				if (it.mode < MODE_ABS || it.mode > MODE_REL)
					return finish_fetch(it.pc, 16'd0);
				st.busy = 1'b1;
				return read_request(it.pc, STEP_LOW);
			end
			if (!st.busy)
				return skipped();
			word = {it.read_data, st.low_byte};
			zp_x_sum = it.read_data + st.held_x;
			zp_y_sum = it.read_data + st.held_y;
			offset = {{8{it.read_data[7]}}, it.read_data};
			case (st.held_mode)
				MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_IND: begin
					if (st.step_count == STEP_LOW) begin
						st.low_byte = it.read_data;
						return read_request(st.program_counter + 16'd1, STEP_HIGH);
					end
					if (st.step_count == STEP_HIGH) begin
						case (st.held_mode)
							MODE_ABS:  return finish_fetch(word, 16'd2);
							MODE_ABSX: return finish_fetch(word + {8'h00, st.held_x}, 16'd2);
							MODE_ABSY: return finish_fetch(word + {8'h00, st.held_y}, 16'd2);
							default: begin
								st.pointer_address = word;
								return read_request(word, STEP_PTR_LOW);
							end
						endcase
					end
				end
				MODE_ZP:  return finish_fetch({8'h00, it.read_data}, 16'd1);
				MODE_ZPX: return finish_fetch({8'h00, zp_x_sum}, 16'd1);
				MODE_ZPY: return finish_fetch({8'h00, zp_y_sum}, 16'd1);
				MODE_INDX, MODE_INDY: begin
					if (st.step_count == STEP_LOW) begin
						st.pointer_address = {8'h00,
							(st.held_mode == MODE_INDX) ? zp_x_sum : it.read_data};
						return read_request(st.pointer_address, STEP_PTR_LOW);
					end
				end
				MODE_REL: return finish_fetch(st.program_counter + 16'd1 + offset, 16'd1);
				default: begin
					st.busy = 1'b0;
					st.step_count = STEP_LOW;
					return skipped();
				end
			endcase
			// pointer dereference shared by the indirect modes; high byte stays in page
			if (st.step_count == STEP_PTR_LOW) begin
				st.low_byte = it.read_data;
				return read_request({st.pointer_address[15:8], st.pointer_address[7:0] + 8'd1},
					STEP_PTR_HI);
			end
			if (st.held_mode == MODE_IND)
				return finish_fetch(word, 16'd2);
			if (st.held_mode == MODE_INDY)
				return finish_fetch(word + {8'h00, st.held_y}, 16'd1);
			return finish_fetch(word, 16'd1);
		endfunction

		function void note_item(item_t it);
			expected_results.push_back(fetch_step(it));
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %0d %h %h",
					$time, got.kind, got.address, got.next_pc);
				return;
			end
			want = expected_results.pop_front();
			compare_field("kind", {14'd0, want.kind}, {14'd0, got.kind});
			compare_field("address", want.address, got.address);
			compare_field("next_pc", want.next_pc, got.next_pc);
		endfunction

		function int outstanding();
			return expected_results.size();
		endfunction

		function void report_leftover();
			if (expected_results.size() != 0) begin
				errors += expected_results.size();
				$display("%0t: missing results, expected %0d more, actual 0",
					$time, expected_results.size());
			end
		endfunction
	endclass

endpackage

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// top-level bench for the operand address generator
module tb_top;
	import oag_pkg::*;
	import agen_check_pkg::*;

	localparam int         RANDOM_ITEMS   = 450;
	localparam int         LONG_HOLD      = 60;
	localparam logic [3:0] MODE_UNUSED_HI = 4'hF;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item_word = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result_word;

	agen_scoreboard sb = new();
	int  items_sent = 0;
	bit  no_idle = 1'b0;
	bit  hold_output = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	operand_address_generator_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_word)
	);

	always @(posedge clk) begin
		if (item_valid && !item_stall)
			sb.note_item(item_word);
		if (result_valid && !result_stall)
			sb.check_result(result_word);
	end

	function automatic logic [15:0] wide_value();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h00FF;
			3: return 16'hFF00;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] byte_value();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h7F;
			3: return 8'h80;
			default: return 8'($urandom);
		endcase
	endfunction

	// called right after the previous acceptance edge, or while valid is low
	task automatic send_item(item_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item_word <= it;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	task automatic start_item(logic [3:0] mode, logic [15:0] pc, logic [7:0] x, logic [7:0] y);
		item_t it;
		it.op = OP_START;
		it.mode = mode;
		it.pc = pc;
		it.x_index = x;
		it.y_index = y;
		it.read_data = 8'($urandom);
		send_item(it);
	endtask

	// fields other than read_data carry noise that the block must ignore
	task automatic data_item(logic [7:0] value);
		item_t it;
		it.op = OP_DATA;
		it.mode = 4'($urandom);
		it.pc = 16'($urandom);
		it.x_index = 8'($urandom);
		it.y_index = 8'($urandom);
		it.read_data = value;
		send_item(it);
	endtask

	task automatic random_fetch();
		logic [3:0] mode;
		int need;
		int count;
		int shape;
		if ($urandom_range(0, 9) == 0)
			mode = 4'($urandom_range(13, 15));
		else
			mode = 4'($urandom_range(0, 12));
		case (mode)
			MODE_ABS, MODE_ABSX, MODE_ABSY: need = 2;
			MODE_IND: need = 4;
			MODE_INDX, MODE_INDY: need = 3;
			MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_REL: need = 1;
			default: need = 0;
		endcase
		// mostly complete fetches; some cut short by a new start, some with stray data
		shape = $urandom_range(0, 9);
		count = need;
		if (shape == 0 && need > 0)
			count = $urandom_range(0, need - 1);
		else if (shape == 1)
			count = need + $urandom_range(1, 2);
		start_item(mode, wide_value(), byte_value(), byte_value());
		repeat (count) data_item(byte_value());
	endtask

	task automatic drain_results();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	initial begin : result_sink
		int wait_cycles;
		forever begin
			if (hold_output) begin
				@(negedge clk);
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_output = 1'b0;
			end
			wait_cycles = no_idle ? 0 : $urandom_range(0, 4);
			if (wait_cycles > 0) begin
				@(negedge clk);
				result_stall <= 1'b1;
				repeat (wait_cycles - 1) @(negedge clk);
			end
			@(negedge clk);
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid && !hold_output);
		end
	end

	initial begin : stimulus
		bit held_once;
		bit drained_once;
		held_once = 1'b0;
		drained_once = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		data_item(8'hFF);                                  // data with no fetch open
		start_item(MODE_IMP, 16'hFFFF, 8'h00, 8'hFF);
		start_item(MODE_IMM, 16'hFFFF, 8'hFF, 8'h00);      // next_pc wraps to zero
		start_item(MODE_UNUSED_HI, 16'h1234, 8'hFF, 8'hFF);
		start_item(MODE_ABSX, 16'hFFFF, 8'hFF, 8'h00);     // operand address wraps
		data_item(8'hFF);
		data_item(8'hFF);
		start_item(MODE_ZPX, 16'h0000, 8'hFF, 8'h00);      // stays in page zero
		data_item(8'h80);
		start_item(MODE_REL, 16'hFFFE, 8'h00, 8'h00);      // negative offset
		data_item(8'h80);
		start_item(MODE_IND, 16'h8000, 8'h00, 8'h00);      // pointer at end of page
		data_item(8'hFF);
		data_item(8'h10);
		data_item(8'h34);
		data_item(8'h12);
		start_item(MODE_INDY, 16'h0000, 8'h00, 8'hFF);     // zero-page pointer at 0xff
		data_item(8'hFF);
		data_item(8'hFF);
		data_item(8'hFF);
		start_item(MODE_ABS, 16'h1234, 8'h00, 8'h00);      // abandoned by next start
		start_item(MODE_INDX, 16'h4321, 8'hFF, 8'h00);
		data_item(8'h01);
		data_item(8'h00);
		data_item(8'h80);

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			no_idle = (items_sent >= 120 && items_sent < 150) ||
				(items_sent >= 300 && items_sent < 360);
			if (!held_once && items_sent >= 120) begin
				held_once = 1'b1;
				hold_output = 1'b1;
			end
			if (!drained_once && items_sent >= 260) begin
				drained_once = 1'b1;
				drain_results();
			end
			random_fetch();
		end
		no_idle = 1'b0;

		drain_results();
		repeat (20) @(posedge clk);
		sb.report_leftover();
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
